/* rtl/tsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text space collapse package
// Shared item types, character codes and queue sizes for the text space
// collapse and capitalising block.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CAP_WIDTH           = 16;
   localparam int LEN_WIDTH           = 16;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd256;

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SMALL_I    = 8'h69;
   localparam logic [7:0] CHAR_CAPITAL_I  = 8'h49;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_PERIOD     = 8'h2E;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 3;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [7:0]           out_char;
      logic                 is_last;
      logic [LEN_WIDTH-1:0] total_len;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

/* rtl/tsc_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue that takes up to two result items per cycle and hands one
// item per cycle to the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module tsc_outq (
   input  logic              clock,
   input  logic              reset,
   input  tsc_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsc_pkg::rsp_type  rsp_data
);
   import tsc_pkg::*;

   rsp_type                mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [OQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [OQ_CNT_W-1:0]    count_ff, count_in;
   logic [OQ_PTR_W-1:0]    wr_next;
   logic                   pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= OQ_CNT_W'(OQ_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + OQ_PTR_W'(1);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + OQ_PTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + OQ_PTR_W'(push.count);
      count_in  = count_ff + OQ_CNT_W'(push.count) - OQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

/* rtl/tsc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text space collapse core
// Input register, per-text state and the single-pass logic that turns one
// input item into up to two result items.
// ----------------------------------------------------------------------------
module tsc_core #(
   parameter int COUNT_WIDTH = tsc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tsc_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [tsc_pkg::CAP_WIDTH-1:0]   csr_wdata,
   input  logic                            room,
   output tsc_pkg::push_type               push
);
   import tsc_pkg::*;

   localparam int LW = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;

   logic                   in_valid_ff, in_valid_in;
   req_type                in_data_ff;
   logic [CAP_WIDTH-1:0]   cap_ff;
   logic                   after_space_ff, after_space_in;
   logic                   space_pending_ff, space_pending_in;
   logic                   held_i_ff, held_i_in;
   logic                   limit_ff, limit_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic          fire, accept;
   logic [7:0]    c;
   logic          text_end, ws, holdable, fits, capital;
   logic [LW-1:0] count_max, lim, char_limit, sum, count_ext;
   logic          a_v, b_v, c_v;
   rsp_type       a_item, b_item, c_item;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   assign c         = in_data_ff.ch;
   assign text_end  = in_data_ff.is_end || (c == CHAR_NUL);
   assign ws        = is_space(c);
   assign holdable  = after_space_ff && (c == CHAR_SMALL_I);
   assign capital   = text_end || ws || (c == CHAR_APOSTROPHE) || (c == CHAR_COMMA)
                      || (c == CHAR_PERIOD);

   assign count_max  = LW'({COUNT_WIDTH{1'b1}});
   assign lim        = (cap_ff == '0) ? '0 : LW'(cap_ff) - LW'(1);
   assign char_limit = (lim > count_max) ? count_max : lim;
   assign count_ext  = LW'(count_ff);
   assign sum        = count_ext + (space_pending_ff ? LW'(2) : LW'(1));
   assign fits       = !limit_ff && (sum <= char_limit);

   always_comb begin
      a_v    = held_i_ff;
      a_item = rsp_type'{out_char: capital ? CHAR_CAPITAL_I : CHAR_SMALL_I,
                         is_last: 1'b0, total_len: '0};
      b_v    = text_end || (!ws && fits && space_pending_ff);
      b_item = text_end ? rsp_type'{out_char: CHAR_NUL, is_last: 1'b1,
                                    total_len: count_ext[LEN_WIDTH-1:0]}
                        : rsp_type'{out_char: CHAR_SPACE, is_last: 1'b0,
                                    total_len: '0};
      c_v    = !text_end && !ws && fits && !holdable;
      c_item = rsp_type'{out_char: c, is_last: 1'b0, total_len: '0};

      push.count  = fire ? (2'(a_v) + 2'(b_v) + 2'(c_v)) : 2'd0;
      push.first  = a_v ? a_item : (b_v ? b_item : c_item);
      push.second = (a_v && b_v) ? b_item : c_item;
   end

   always_comb begin
      after_space_in   = after_space_ff;
      space_pending_in = space_pending_ff;
      held_i_in        = held_i_ff;
      limit_in         = limit_ff;
      count_in         = count_ff;
      if (fire) begin
         held_i_in = 1'b0;
         if (text_end) begin
            after_space_in   = 1'b1;
            space_pending_in = 1'b0;
            limit_in         = 1'b0;
            count_in         = '0;
         end else if (ws) begin
            space_pending_in = space_pending_ff || (!after_space_ff && !limit_ff);
            after_space_in   = 1'b1;
         end else begin
            if (fits) begin
               held_i_in = holdable;
               count_in  = sum[COUNT_WIDTH-1:0];
            end else begin
               limit_in = 1'b1;
            end
            space_pending_in = 1'b0;
            after_space_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         cap_ff           <= CAP_RESET;
         after_space_ff   <= 1'b1;
         space_pending_ff <= 1'b0;
         held_i_ff        <= 1'b0;
         limit_ff         <= 1'b0;
         count_ff         <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         after_space_ff   <= after_space_in;
         space_pending_ff <= space_pending_in;
         held_i_ff        <= held_i_in;
         limit_ff         <= limit_in;
         count_ff         <= count_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

endmodule

/* rtl/text_space_collapse_and_i_capitalizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text space collapse and capitalising top level
// Collapses whitespace runs, trims leading and trailing whitespace, turns a
// stand-alone small i into a capital and reports the length of each text.
// ----------------------------------------------------------------------------
// Text bytes arrive on the req_ channel, one byte per item; an item with
// is_end set, or a zero byte, closes the text. Character items and one final
// item carrying total_len leave on the rsp_ channel. An item is taken when
// valid is high and stall is low.
// An accepted item is registered, processed once the queue has room and
// written to a four-entry result queue. One item is accepted per cycle while
// req_stall is low; an item that yields two results (a resolved held i
// together with a character or the end item) writes both into the queue at
// once, and the queue absorbs the extra result.
// req_stall is high while an item waits in the input register and the queue
// has room for fewer than two results.
// csr_we writes the output capacity in csr_wdata; it should only be written
// while no text is in flight. Reset empties the queue, clears the per-text
// state and sets the capacity to 256. A stalled receiver holds its item and
// fills the queue, after which the input is stalled too.
// ----------------------------------------------------------------------------
module text_space_collapse_and_i_capitalizer #(
   parameter int COUNT_WIDTH = tsc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tsc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tsc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [tsc_pkg::CAP_WIDTH-1:0] csr_wdata
);
   import tsc_pkg::*;

   push_type push;
   logic     room;

   tsc_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .room     (room),
      .push     (push)
   );

   tsc_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/tsc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text space collapse checker
// Port-level checks on the text space collapse block, bound to its top level.
// ----------------------------------------------------------------------------
module tsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tsc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tsc_pkg::rsp_type rsp_data
);
   import tsc_pkg::*;

   // After reset the queue is empty and the input register is free.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not cleared after reset");

   // With no result waiting there is always room, so the input never stalls.
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty result queue");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled input item changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_last_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_last |-> rsp_data.out_char == CHAR_NUL)
      else $error("end item carries a character");

endmodule

bind text_space_collapse_and_i_capitalizer tsc_checker u_tsc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
